/* design/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg - shared definitions for the stack fold reducer
// Action codes, status codes and field widths used by the reducer.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // field widths
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [VALUE_W-1:0]  value_t;

    // action codes
    localparam action_t ACT_PUSH = 3'd0;
    localparam action_t ACT_ADD  = 3'd1;
    localparam action_t ACT_SUB  = 3'd2;
    localparam action_t ACT_MUL  = 3'd3;
    localparam action_t ACT_DIV  = 3'd4;

    // status codes
    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_IGNORED = 2'd1;
    localparam status_t ST_FULL    = 2'd2;
    localparam status_t ST_DIVZERO = 2'd3;

    // divider step counter width
    localparam int DIV_CNT_W = 5;

endpackage

/* design/stack_fold_reducer_top.sv */
// ----------------------------------------------------------------------------
// stack_fold_reducer_top - stack of signed values with whole-stack folds
// Pushes values onto a stack memory and folds the stack with +, -, * or /.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the action code,
//   tdata the operand. Each request gives exactly one response on m_axis:
//   tdata carries the bottom entry and the entry count, tuser the status.
//   A push, ignored or refused request is answered from the output register,
//   and the next request can be taken while that response drains.
//   A fold reads the top entry, then does one memory read and one accumulate
//   per entry below the top for add, subtract and multiply, plus the final
//   write back; for divide, each entry below the top takes one step state and
//   then a run of the one-bit-per-cycle restoring divider. A divide by zero
//   stops at the first zero entry met walking down from the top.
//   Reset empties the stack (count zero); the memory itself is not cleared
//   and needs no clearing pass.
//   A stalled response holds in the output register; a new request is taken
//   only while that register is empty or being drained, so nothing is lost.
// ----------------------------------------------------------------------------
module stack_fold_reducer_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [31:0] operand_value
    input  logic [31:0]             s_axis_tdata,
    // [2:0] action
    input  logic [2:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [31:0] bottom_value, [38:32] entry_count, [39] zero fill
    output logic [39:0]             m_axis_tdata,
    // [1:0] status
    output logic [1:0]              m_axis_tuser
);
    import sfr_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOP,
        S_STEP,
        S_DIV,
        S_WRITE
    } state_t;

    // stack memory
    value_t mem [STACK_DEPTH];
    value_t rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    value_t            wr_data;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    value_t            bottom_reg, bottom_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    action_t           op_reg, op_next;
    value_t            acc_reg, acc_next;
    value_t            dvd_reg, dvd_next;
    value_t            rem_reg, rem_next;
    value_t            dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic              out_valid_reg, out_valid_next;
    value_t            out_bottom_reg, out_bottom_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    status_t           out_status_reg, out_status_next;

    logic              in_take;
    action_t           in_action;
    value_t            in_value;
    value_t            entry;
    logic [VALUE_W:0]  trial;
    logic              q_bit;
    value_t            q_final;
    value_t            acc_mag;
    value_t            ent_mag;

    assign in_action     = s_axis_tuser;
    assign in_value      = s_axis_tdata;
    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign entry         = rd_data_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_count_reg, out_bottom_reg};
    assign m_axis_tuser  = out_status_reg;

    // divider datapath: one quotient bit per cycle
    assign trial   = {rem_reg, dvd_reg[VALUE_W-1]};
    assign q_bit   = (trial >= {1'b0, dvs_reg});
    assign q_final = {dvd_reg[VALUE_W-2:0], q_bit};
    assign acc_mag = acc_reg[VALUE_W-1] ? (value_t'(0) - acc_reg) : acc_reg;
    assign ent_mag = entry[VALUE_W-1] ? (value_t'(0) - entry) : entry;

    // memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        bottom_next     = bottom_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        acc_next        = acc_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        neg_next        = neg_reg;
        bit_cnt_next    = bit_cnt_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_bottom_next = out_bottom_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[ADDR_W-1:0];
        wr_data         = in_value;

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = ADDR_W'(count_reg - CNT_W'(1));
                if (in_take)
                begin
                    out_valid_next  = 1'b1;
                    out_bottom_next = (count_reg != '0) ? bottom_reg : '0;
                    out_count_next  = COUNT_W'(count_reg);
                    out_status_next = ST_IGNORED;
                    if (in_action == ACT_PUSH)
                    begin
                        if (in_value == '0)
                        begin
                            out_status_next = ST_IGNORED;
                        end
                        else if (count_reg >= CNT_W'(STACK_DEPTH))
                        begin
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            // push onto the top
                            wr_en           = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            out_count_next  = COUNT_W'(count_reg + CNT_W'(1));
                            out_status_next = ST_DONE;
                            if (count_reg == '0)
                            begin
                                bottom_next     = in_value;
                                out_bottom_next = in_value;
                            end
                        end
                    end
                    else if ((in_action == ACT_ADD || in_action == ACT_SUB ||
                              in_action == ACT_MUL || in_action == ACT_DIV) &&
                             count_reg >= CNT_W'(2))
                    begin
                        // start a fold: top entry is being read now
                        out_valid_next = 1'b0;
                        op_next        = in_action;
                        idx_next       = ADDR_W'(count_reg - CNT_W'(2));
                        state_next     = S_TOP;
                    end
                end
            end

            S_TOP:
            begin
                acc_next   = entry;
                rd_addr    = idx_reg;
                state_next = S_STEP;
            end

            S_STEP:
            begin
                rd_addr = idx_reg - ADDR_W'(1);
                case (op_reg)
                    ACT_ADD: acc_next = acc_reg + entry;
                    ACT_SUB: acc_next = acc_reg - entry;
                    ACT_MUL: acc_next = value_t'(acc_reg * entry);
                    default: acc_next = acc_reg;
                endcase
                if (op_reg == ACT_DIV)
                begin
                    if (entry == '0)
                    begin
                        // divide by zero: stack left as it was
                        out_valid_next  = 1'b1;
                        out_bottom_next = bottom_reg;
                        out_count_next  = COUNT_W'(count_reg);
                        out_status_next = ST_DIVZERO;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        dvd_next     = acc_mag;
                        dvs_next     = ent_mag;
                        rem_next     = '0;
                        neg_next     = acc_reg[VALUE_W-1] ^ entry[VALUE_W-1];
                        bit_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next = idx_reg - ADDR_W'(1);
                end
            end

            S_DIV:
            begin
                rd_addr      = idx_reg - ADDR_W'(1);
                dvd_next     = q_final;
                rem_next     = q_bit ? value_t'(trial - {1'b0, dvs_reg}) : trial[VALUE_W-1:0];
                bit_cnt_next = bit_cnt_reg + DIV_CNT_W'(1);
                if (bit_cnt_reg == '1)
                begin
                    acc_next = neg_reg ? (value_t'(0) - q_final) : q_final;
                    if (idx_reg == '0)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        // next entry read issued this cycle
                        idx_next   = idx_reg - ADDR_W'(1);
                        state_next = S_STEP;
                    end
                end
            end

            S_WRITE:
            begin
                // folded value replaces the stack
                wr_en           = 1'b1;
                wr_addr         = '0;
                wr_data         = acc_reg;
                count_next      = CNT_W'(1);
                bottom_next     = acc_reg;
                out_valid_next  = 1'b1;
                out_bottom_next = acc_reg;
                out_count_next  = COUNT_W'(1);
                out_status_next = ST_DONE;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bottom_reg     <= bottom_next;
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        acc_reg        <= acc_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        neg_reg        <= neg_next;
        out_bottom_reg <= out_bottom_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

endmodule
